// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
// Uses clk_i and rst_ni of the including module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define NLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NLF_ASSERT_NEVER(lbl, cond, msg) `NLF_ASSERT(lbl, !(cond), msg)
`else
`define NLF_ASSERT(lbl, prop, msg)
`define NLF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/nlf_pkg.sv =====
// ---------------------------------------------------------------------------
// nlf_pkg
// Types and Q2.30 constants of the single-precision natural log pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package nlf_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // mantissa segment chosen in the front end
  typedef enum logic [1:0] {
    SEG_DIRECT = 2'd0,
    SEG_K1     = 2'd1,
    SEG_K2     = 2'd2
  } seg_e;

  // per-word sideband that rides along the pipeline
  typedef struct packed {
    logic              domain;
    logic signed [8:0] expo;
    seg_e              seg;
    logic              neg;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // Q2.30 constants, rounded to nearest
  localparam logic [29:0]        LIM1     = 30'd944419889;
  localparam logic [29:0]        LIM2     = 30'd708405415;
  localparam logic [30:0]        K1       = 31'd1416810831;
  localparam logic [30:0]        K2       = 31'd1869493100;
  localparam logic signed [31:0] LNK1     = 32'sd297704447;
  localparam logic signed [31:0] LNK2     = 32'sd595408894;
  localparam logic [28:0]        CB       = 29'd286950523;
  localparam logic [29:0]        CC       = 30'd644863570;
  localparam logic [29:0]        LN2      = 30'd744261117;
  localparam logic [30:0]        ONE_Q30  = 31'h4000_0000;

  // divider geometry
  localparam int ZW    = 27;   // |z| quotient bits
  localparam int D1_DW = 32;
  localparam int D1_NW = 59;
  localparam int TW    = 29;   // rational term quotient bits
  localparam int D2_DW = 31;
  localparam int D2_NW = 60;

endpackage

`default_nettype wire

// ===== rtl/natural_log_float32.sv =====
// ---------------------------------------------------------------------------
// natural_log_float32
// Natural log of an IEEE-754 single-precision word, signed fixed-point out.
// ---------------------------------------------------------------------------
// Fully pipelined: a word is taken on every cycle that start is high (busy
// is always low) and its result appears on log_value_o / domain_error_o with
// done_o high after 4 decode/scale stages, a 27-stage divider for z, 6
// polynomial stages, a 29-stage divider for the rational term and 3 stages
// for the exponent sum, rounding and output register.
// The receiver cannot stall, so results must be taken when done_o is high.
// Zero or negative operands give domain_error_o = 1 and the most negative
// value; infinities and NaNs are treated as exponent 129.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module natural_log_float32 #(
  parameter int FRAC_BITS = nlf_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] float_bits_i,
  output logic             done_o,
  output logic signed [31:0] log_value_o,
  output logic             domain_error_o
);

  localparam int SH = 30 - FRAC_BITS;

  logic                        f_vld, d1_vld, p_vld, d2_vld;
  logic [nlf_pkg::D1_NW-1:0]   f_num;
  logic [nlf_pkg::D1_DW-1:0]   f_den;
  nlf_pkg::side_t              f_side, d1_side, p_side, d2_side;
  logic [nlf_pkg::SIDE_W-1:0]  d1_sv, d2_sv;
  logic [nlf_pkg::ZW-1:0]      zmag;
  logic [nlf_pkg::D2_NW-1:0]   p_num;
  logic [nlf_pkg::D2_DW-1:0]   p_den;
  logic [nlf_pkg::TW-1:0]      q2;

  logic [2:0]                  vld_q;
  logic                        dom1_q, dom2_q;
  logic signed [31:0]          qs, sub, seg_d, seg_q;
  logic signed [39:0]          ep_d, ep_q;
  logic signed [40:0]          tot_q;
  logic [40:0]                 mag, rnd;
  logic signed [31:0]          res_d;

  assign busy = 1'b0;

  nlf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start & ~busy),
    .float_bits_i (float_bits_i),
    .valid_o      (f_vld),
    .num_o        (f_num),
    .den_o        (f_den),
    .side_o       (f_side)
  );

  nlf_div #(
    .NW (nlf_pkg::D1_NW),
    .DW (nlf_pkg::D1_DW),
    .QW (nlf_pkg::ZW),
    .SW (nlf_pkg::SIDE_W)
  ) u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d1_vld),
    .quo_o   (zmag),
    .side_o  (d1_sv)
  );

  assign d1_side = d1_sv;

  nlf_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_vld),
    .zmag_i  (zmag),
    .side_i  (d1_side),
    .valid_o (p_vld),
    .num_o   (p_num),
    .den_o   (p_den),
    .side_o  (p_side)
  );

  nlf_div #(
    .NW (nlf_pkg::D2_NW),
    .DW (nlf_pkg::D2_DW),
    .QW (nlf_pkg::TW),
    .SW (nlf_pkg::SIDE_W)
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_vld),
    .num_i   (p_num),
    .den_i   (p_den),
    .side_i  (p_side),
    .valid_o (d2_vld),
    .quo_o   (q2),
    .side_o  (d2_sv)
  );

  assign d2_side = d2_sv;

  // tail stage 1: signed segment value and exponent product
  always_comb begin
    qs = d2_side.neg ? -$signed({3'b0, q2}) : $signed({3'b0, q2});
    case (d2_side.seg)
      nlf_pkg::SEG_DIRECT: sub = 32'sd0;
      nlf_pkg::SEG_K1:     sub = nlf_pkg::LNK1;
      nlf_pkg::SEG_K2:     sub = nlf_pkg::LNK2;
      default:             sub = nlf_pkg::LNK2;
    endcase
    seg_d = qs - sub;
    ep_d  = 40'(d2_side.expo) * $signed({10'b0, nlf_pkg::LN2});
  end

  // tail stage 3: round to FRAC_BITS, ties away from zero, saturate, and give the most negative value on a domain error
  always_comb begin
    mag = tot_q[40] ? 41'(-tot_q) : 41'(tot_q);
    rnd = (mag + (41'd1 << (SH - 1))) >> SH;
    if (!tot_q[40]) begin
      res_d = (rnd > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rnd[31:0]);
    end else begin
      res_d = (rnd > 41'h0_8000_0000) ? 32'sh8000_0000 : $signed(-rnd[31:0]);
    end
    if (dom2_q) begin
      res_d = 32'sh8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], d2_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q          <= seg_d;
    ep_q           <= ep_d;
    dom1_q         <= d2_side.domain;
    tot_q          <= 41'(ep_q) + 41'(seg_q);
    dom2_q         <= dom1_q;
    log_value_o    <= res_d;
    domain_error_o <= dom2_q;
  end

  assign done_o = vld_q[2];

  `NLF_ASSERT(a_domain_value, (done_o && domain_error_o) |-> (log_value_o == 32'sh8000_0000), "domain error without minimum value")
  `NLF_ASSERT(a_done_follows, done_o |-> $past(vld_q[1]), "done without a word in the tail")
  `NLF_ASSERT_NEVER(a_busy_low, busy, "busy raised on a pipeline that cannot stall")

endmodule

`default_nettype wire

// ===== rtl/nlf_div.sv =====
// ---------------------------------------------------------------------------
// nlf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num < den * 2^QW.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nlf_div #(
  parameter int NW = nlf_pkg::D1_NW,
  parameter int DW = nlf_pkg::D1_DW,
  parameter int QW = nlf_pkg::ZW,
  parameter int SW = nlf_pkg::SIDE_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld_q  [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic          vin;
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [NW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_head
      assign vin = valid_i;
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_body
      assign vin = vld_q[i-1];
      assign rin = rem_q[i-1];
      assign din = den_q[i-1];
      assign qin = quo_q[i-1];
      assign sin = side_q[i-1];
    end

    // trial subtract of the shifted divisor
    assign trial = {1'b0, rin} - ({1'b0, NW'(din)} << K);
    assign ge    = ~trial[NW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? trial[NW-1:0] : rin;
      den_q[i]  <= din;
      quo_q[i]  <= qin | (ge ? (QW'(1) << K) : '0);
      side_q[i] <= sin;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

  `NLF_ASSERT(a_rem_below_den, vld_q[QW-1] |-> (rem_q[QW-1] < NW'(den_q[QW-1])), "div remainder not reduced")
  `NLF_ASSERT(a_valid_flow, vld_q[QW-1] |-> $past(vld_q[QW-2]), "div valid out of sequence")

endmodule

`default_nettype wire

// ===== rtl/nlf_front.sv =====
// ---------------------------------------------------------------------------
// nlf_front
// Operand decode, segment scaling and the first dividend (x-1)/(x+1).
// Four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module nlf_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [31:0]                float_bits_i,
  output logic                            valid_o,
  output logic [nlf_pkg::D1_NW-1:0]       num_o,
  output logic [nlf_pkg::D1_DW-1:0]       den_o,
  output nlf_pkg::side_t                  side_o
);

  logic [3:0]     vld_q;
  nlf_pkg::side_t s1_q, s2_q, s3_q, s4_q;
  nlf_pkg::side_t s1_d, s4_d;
  logic [29:0]    m1_d, m1_q, m2_q;
  logic [60:0]    p2_d, p2_q;
  logic [30:0]    kmul;
  logic [60:0]    prnd;
  logic [30:0]    x3_d, x3_q;
  logic [30:0]    mag4;
  logic [31:0]    den4_d, den4_q;
  logic [nlf_pkg::D1_NW-1:0] num4_d, num4_q;

  // stage 1: decode sign, exponent, mantissa and segment
  always_comb begin
    m1_d        = {1'b1, float_bits_i[22:0], 6'b0};
    s1_d.domain = float_bits_i[31] | (float_bits_i[30:0] == 31'd0);
    s1_d.expo   = 9'($signed({1'b0, float_bits_i[30:23]}) - 9'sd126);
    s1_d.neg    = 1'b0;
    if (m1_d >= nlf_pkg::LIM1) begin
      s1_d.seg = nlf_pkg::SEG_DIRECT;
    end else if (m1_d >= nlf_pkg::LIM2) begin
      s1_d.seg = nlf_pkg::SEG_K1;
    end else begin
      s1_d.seg = nlf_pkg::SEG_K2;
    end
  end

  // stage 2: scale factor product
  always_comb begin
    case (s1_q.seg)
      nlf_pkg::SEG_K1: kmul = nlf_pkg::K1;
      nlf_pkg::SEG_K2: kmul = nlf_pkg::K2;
      default:         kmul = nlf_pkg::K2;
    endcase
    p2_d = 61'(m1_q) * 61'(kmul);
  end

  // stage 3: round the product back to Q2.30
  always_comb begin
    prnd = p2_q + (61'd1 << 29);
    x3_d = (s2_q.seg == nlf_pkg::SEG_DIRECT) ? {1'b0, m2_q} : prnd[60:30];
  end

  // stage 4: |x-1| scaled by 2^30 plus half the divisor, for round to nearest
  always_comb begin
    s4_d     = s3_q;
    s4_d.neg = (x3_q < nlf_pkg::ONE_Q30);
    mag4     = s4_d.neg ? (nlf_pkg::ONE_Q30 - x3_q) : (x3_q - nlf_pkg::ONE_Q30);
    den4_d   = {1'b0, x3_q} + {1'b0, nlf_pkg::ONE_Q30};
    num4_d   = (nlf_pkg::D1_NW'(mag4) << 30) + nlf_pkg::D1_NW'(den4_d >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= s1_d;
    m1_q   <= m1_d;
    s2_q   <= s1_q;
    m2_q   <= m1_q;
    p2_q   <= p2_d;
    s3_q   <= s2_q;
    x3_q   <= x3_d;
    s4_q   <= s4_d;
    num4_q <= num4_d;
    den4_q <= den4_d;
  end

  assign valid_o = vld_q[3];
  assign num_o   = num4_q;
  assign den_o   = den4_q;
  assign side_o  = s4_q;

endmodule

`default_nettype wire

// ===== rtl/nlf_poly.sv =====
// ---------------------------------------------------------------------------
// nlf_poly
// Rational term: z^2, numerator and denominator polynomials, and the
// second dividend 2z(1-b z^2) over (1-c z^2). Six register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module nlf_poly (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [nlf_pkg::ZW-1:0] zmag_i,
  input  wire nlf_pkg::side_t        side_i,
  output logic                       valid_o,
  output logic [nlf_pkg::D2_NW-1:0]  num_o,
  output logic [nlf_pkg::D2_DW-1:0]  den_o,
  output nlf_pkg::side_t             side_o
);

  localparam int ZW = nlf_pkg::ZW;

  logic [5:0]     vld_q;
  nlf_pkg::side_t sd_q [6];
  logic [ZW-1:0]  z_q  [4];
  logic [53:0]    z2p_q, z2r;
  logic [23:0]    z2_q;
  logic [53:0]    cbp_q, ccp_q, cbr, ccr;
  logic [30:0]    nump_q, denp_q, denp5_q;
  logic [57:0]    tp_q, tr;
  logic [28:0]    tmag;
  logic [nlf_pkg::D2_NW-1:0] num6_q;
  logic [30:0]    den6_q;

  // rounding of the Q2.30 products
  assign z2r  = z2p_q + (54'd1 << 29);
  assign cbr  = cbp_q + (54'd1 << 29);
  assign ccr  = ccp_q + (54'd1 << 29);
  assign tr   = tp_q + (58'd1 << 29);
  assign tmag = {tr[57:30], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // sideband and |z| delay line
    sd_q[0] <= side_i;
    for (int i = 1; i < 6; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
    z_q[0] <= zmag_i;
    for (int i = 1; i < 4; i++) begin
      z_q[i] <= z_q[i-1];
    end
    // z^2
    z2p_q   <= 54'(zmag_i) * 54'(zmag_i);
    z2_q    <= z2r[53:30];
    // b*z^2 and c*z^2
    cbp_q   <= 54'(nlf_pkg::CB) * 54'(z2_q);
    ccp_q   <= 54'(nlf_pkg::CC) * 54'(z2_q);
    nump_q  <= nlf_pkg::ONE_Q30 - 31'(cbr[53:30]);
    denp_q  <= nlf_pkg::ONE_Q30 - 31'(ccr[53:30]);
    // z * numerator
    tp_q    <= 58'(z_q[3]) * 58'(nump_q);
    denp5_q <= denp_q;
    // second dividend with half divisor for rounding
    num6_q  <= (nlf_pkg::D2_NW'(tmag) << 30) + nlf_pkg::D2_NW'(denp5_q >> 1);
    den6_q  <= denp5_q;
  end

  assign valid_o = vld_q[5];
  assign num_o   = num6_q;
  assign den_o   = den6_q;
  assign side_o  = sd_q[5];

endmodule

`default_nettype wire

// ===== tb/sv/natural_log_float32_test.sv =====
// ---------------------------------------------------------------------------
// natural_log_float32_test
// Self-checking bench for the single-precision natural log pipeline: a
// driver feeds operand words from a queue, a monitor compares each result
// word against a fixed-point Q2.30 predictor of the same arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module natural_log_float32_test;

  localparam int FRAC_BITS = 24;
  localparam int LATENCY   = 69;
  localparam int LIMIT     = 200000;

  localparam longint Q_ONE = 64'sd1 << 30;
  localparam longint Q_LIM1 = 64'sd944419889;
  localparam longint Q_LIM2 = 64'sd708405415;
  localparam longint Q_K1   = 64'sd1416810831;
  localparam longint Q_K2   = 64'sd1869493100;
  localparam longint Q_LNK1 = 64'sd297704447;
  localparam longint Q_LNK2 = 64'sd595408894;
  localparam longint Q_CB   = 64'sd286950523;
  localparam longint Q_CC   = 64'sd644863570;
  localparam longint Q_LN2  = 64'sd744261117;

  typedef struct packed {
    logic signed [31:0] log_value;
    logic               domain_error;
  } log_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] float_bits_i;
  logic        done_o;
  logic signed [31:0] log_value_o;
  logic        domain_error_o;

  logic [31:0] operand_q[$];
  log_word_t   expected_q[$];
  int          n_errors;
  int          cycle_cnt;
  int          gap_left;
  bit          quiet_mode;

  natural_log_float32 #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .float_bits_i(float_bits_i), .done_o(done_o),
    .log_value_o(log_value_o), .domain_error_o(domain_error_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // round to nearest, ties away from zero
  function automatic longint div_near(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return div_near(a * b, Q_ONE);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    return div_near(n * Q_ONE, d);
  endfunction

  // predicted natural log of one operand word
  function automatic log_word_t predict_log(logic [31:0] bits);
    log_word_t r;
    longint e, m, x, sub, z, z2, nump, denp, t, total, res;
    if (bits[31] || bits[30:0] == 31'd0) begin
      r.log_value = 32'sh8000_0000;
      r.domain_error = 1'b1;
      return r;
    end
    e = longint'(bits[30:23]) - 126;
    m = longint'({1'b1, bits[22:0]}) << 6;
    if (m >= Q_LIM1) begin
      x = m;
      sub = 0;
    end else if (m >= Q_LIM2) begin
      x = qmul(m, Q_K1);
      sub = Q_LNK1;
    end else begin
      x = qmul(m, Q_K2);
      sub = Q_LNK2;
    end
    z = qdiv(x - Q_ONE, x + Q_ONE);
    z2 = qmul(z, z);
    nump = Q_ONE - qmul(Q_CB, z2);
    denp = Q_ONE - qmul(Q_CC, z2);
    t = 2 * qmul(z, nump);
    total = e * Q_LN2 + qdiv(t, denp) - sub;
    res = div_near(total, 64'sd1 << (30 - FRAC_BITS));
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.log_value = res[31:0];
    r.domain_error = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_cnt, what);
    n_errors++;
  endtask

  // driver: one word per accepted start, random idle bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (operand_q.size() > 0 && !(start && !busy && operand_q.size() == 1)) begin
      if (start && !busy) void'(operand_q.pop_front());
      if (!quiet_mode && $urandom_range(0, 15) == 0) begin
        gap_left <= $urandom_range(0, 15);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        float_bits_i <= operand_q[0];
      end
    end else begin
      if (start && !busy && operand_q.size() > 0) void'(operand_q.pop_front());
      start <= 1'b0;
    end
  end

  // monitor: record accepted words, check result words
  always @(posedge clk_i) begin
    log_word_t exp_w;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (start && !busy) expected_q.push_back(predict_log(float_bits_i));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          exp_w = expected_q.pop_front();
          if (domain_error_o !== exp_w.domain_error)
            report_mismatch($sformatf("domain_error %b, expected %b",
                                      domain_error_o, exp_w.domain_error));
          if (log_value_o !== exp_w.log_value)
            report_mismatch($sformatf("log_value %h, expected %h",
                                      log_value_o, exp_w.log_value));
        end
      end
    end
  end

  // random operand: mostly positive normals, some specials
  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[31] = 1'b1;
      1: w[30:23] = 8'd0;
      2: w[30:23] = 8'hff;
      3: w = {1'b0, w[30:0] & 31'h0000_00ff};
      default: w[31] = 1'b0;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$];
    rst_ni = 1'b0;
    start = 1'b0;
    float_bits_i = 32'd0;
    n_errors = 0;
    cycle_cnt = 0;
    gap_left = 0;
    quiet_mode = 1'b0;
    // zero, negatives, subnormals, extremes, infinity, NaN, segment edges
    directed = '{32'h0000_0000, 32'h8000_0000, 32'hbf80_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h007f_ffff, 32'h0080_0000, 32'h3f80_0000,
                 32'h3f7f_ffff, 32'h3f00_0000, 32'h4000_0000, 32'h402d_f854,
                 32'h7f7f_ffff, 32'h7f80_0000, 32'h7fc0_0000, 32'h7fff_ffff,
                 32'h3f61_2bbc, 32'h3f61_2bbb, 32'h3f28_e51c, 32'h3f28_e51b,
                 32'h3f40_0000, 32'h3fff_ffff, 32'hff80_0000, 32'h0040_0000};
    foreach (directed[i]) operand_q.push_back(directed[i]);
    repeat (1000) operand_q.push_back(rand_operand());
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // end of run and timeout
  initial begin
    wait (rst_ni);
    fork
      begin
        wait (cycle_cnt > 700);
        quiet_mode = 1'b1;
        wait (operand_q.size() == 0 && !start);
        wait (expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk_i);
      end
      wait (cycle_cnt >= LIMIT);
    join_any
    if (cycle_cnt >= LIMIT || n_errors > 0 || expected_q.size() > 0)
      $display("*** FAILED ***");
    else
      $display("*** PASSED ***");
    $finish;
  end

endmodule
